/* hw/rtl/gamma_stretch_pixel_remap_unit_macros.svh */
// assertion macros used by the checker file
`ifndef GAMMA_STRETCH_PIXEL_REMAP_UNIT_MACROS_SVH
`define GAMMA_STRETCH_PIXEL_REMAP_UNIT_MACROS_SVH

// same-cycle implication under asynchronous active-low reset
`define GSR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("gsr check failed");

// next-cycle implication under asynchronous active-low reset
`define GSR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("gsr check failed");

`endif

/* hw/rtl/gsr_pkg.sv */
// shared types and constants of the gamma stretch remap unit
package gsr_pkg;

	// fixed-point precision of the internal ratio and power
	localparam int QBITS    = 30;
	// fraction bits of the base-2 logarithm
	localparam int LOG_FRAC = 24;
	// width of the negated logarithm: integer part up to 30, plus fraction
	localparam int NL_W     = 5 + LOG_FRAC;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_ENABLE     = 3'd0,
		REG_STRETCH_MIN = 3'd1,
		REG_STRETCH_MAX = 3'd2,
		REG_GAMMA      = 3'd3,
		REG_MIN_OUTPUT = 3'd4
	} cfg_reg_t;

endpackage

/* hw/rtl/gsr_div.sv */
// pipelined restoring divider, one quotient bit per stage
module gsr_div
	import gsr_pkg::*;
#(
	parameter int PW     = 17,
	parameter int SIDE_W = 18
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              in_v,
	input  logic [PW-1:0]     num,
	input  logic [PW-1:0]     den,
	input  logic [SIDE_W-1:0] side,
	output logic              out_v,
	output logic [QBITS-1:0]  quot,
	output logic [SIDE_W-1:0] side_out
);

	logic              v_s   [0:QBITS];
	logic [PW-1:0]     rem_s [0:QBITS];
	logic [PW-1:0]     den_s [0:QBITS];
	logic [QBITS-1:0]  quo_s [0:QBITS];
	logic [SIDE_W-1:0] sd_s  [0:QBITS];

	// stage zero is the incoming transaction; numerator is below denominator
	assign v_s[0]   = in_v;
	assign rem_s[0] = num;
	assign den_s[0] = den;
	assign quo_s[0] = '0;
	assign sd_s[0]  = side;

	for (genvar j = 1; j <= QBITS; j++) begin : g_step
		logic [PW:0]   trial;
		logic          ge;
		logic [PW-1:0] rem_nxt;

		// shift in a zero, subtract when the divisor fits
		always_comb begin
			trial   = {rem_s[j-1], 1'b0};
			ge      = (trial >= {1'b0, den_s[j-1]});
			rem_nxt = ge ? PW'(trial - {1'b0, den_s[j-1]}) : trial[PW-1:0];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j] <= 1'b0;
			end else if (adv) begin
				v_s[j] <= v_s[j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[j] <= rem_nxt;
				den_s[j] <= den_s[j-1];
				quo_s[j] <= {quo_s[j-1][QBITS-2:0], ge};
				sd_s[j]  <= sd_s[j-1];
			end
		end
	end

	assign out_v    = v_s[QBITS];
	assign quot     = quo_s[QBITS];
	assign side_out = sd_s[QBITS];

endmodule

/* hw/rtl/gsr_log.sv */
// pipelined negated base-2 logarithm of a ratio below one
module gsr_log
	import gsr_pkg::*;
#(
	parameter int SIDE_W = 18
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              in_v,
	input  logic [QBITS-1:0]  x30,
	input  logic [SIDE_W-1:0] side,
	output logic              out_v,
	output logic [NL_W-1:0]   nl,
	output logic [SIDE_W-1:0] side_out
);

	localparam int STEPS = LOG_FRAC;

	// normalisation stage
	logic              v_s1;
	logic [QBITS:0]    m_s1;
	logic [4:0]        ie_s1;
	logic [SIDE_W-1:0] sd_s1;

	logic [4:0]   lz;
	logic [QBITS:0] m_norm;

	// leading zero count over the ratio
	always_comb begin
		lz = 5'd0;
		for (int b = 0; b < QBITS; b++) begin
			if (x30[b]) begin
				lz = 5'(QBITS - 1 - b);
			end
		end
		m_norm = {x30, 1'b0} << lz;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_s1  <= m_norm;
			ie_s1 <= lz + 5'd1;
			sd_s1 <= side;
		end
	end

	// square-and-compare stages, one fraction bit each
	logic              v_s   [0:STEPS];
	logic [QBITS:0]    m_s   [0:STEPS];
	logic [4:0]        ie_s  [0:STEPS];
	logic [STEPS-1:0]  fr_s  [0:STEPS];
	logic [SIDE_W-1:0] sd_s  [0:STEPS];

	assign v_s[0]  = v_s1;
	assign m_s[0]  = m_s1;
	assign ie_s[0] = ie_s1;
	assign fr_s[0] = '0;
	assign sd_s[0] = sd_s1;

	for (genvar i = 1; i <= STEPS; i++) begin : g_sq
		logic [2*QBITS+1:0] sq;
		logic [QBITS+1:0]   top;
		logic [QBITS:0]     m_nxt;

		always_comb begin
			sq    = m_s[i-1] * m_s[i-1];
			top   = sq[2*QBITS+1:QBITS];
			m_nxt = top[QBITS+1] ? top[QBITS+1:1] : top[QBITS:0];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (adv) begin
				v_s[i] <= v_s[i-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				m_s[i]  <= m_nxt;
				ie_s[i] <= ie_s[i-1];
				fr_s[i] <= {fr_s[i-1][STEPS-2:0], top[QBITS+1]};
				sd_s[i] <= sd_s[i-1];
			end
		end
	end

	// integer part minus fraction
	logic              v_s26;
	logic [NL_W-1:0]   nl_s26;
	logic [SIDE_W-1:0] sd_s26;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s26 <= 1'b0;
		end else if (adv) begin
			v_s26 <= v_s[STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nl_s26 <= {ie_s[STEPS], {STEPS{1'b0}}} - {5'd0, fr_s[STEPS]};
			sd_s26 <= sd_s[STEPS];
		end
	end

	assign out_v    = v_s26;
	assign nl       = nl_s26;
	assign side_out = sd_s26;

endmodule

/* hw/rtl/gamma_stretch_pixel_remap_unit.sv */
// top level of the gamma stretch remap unit
//
// one pixel in, one pixel out, no state between pixels
// in_valid/in_ready carry in_pixel, out_valid/out_ready carry out_pixel
// cfg_valid/cfg_ready write cfg_data into the register chosen by cfg_index;
// cfg_ready is always high, write only while no transaction is in flight
// pixels are unsigned fixed point with FRACTION_BITS fraction bits
// the path from acceptance to out_valid holds one setup stage,
// 30 divider stages, 26 logarithm stages, one gamma multiply stage,
// 24 power stages, one shift stage and the output register
// throughput is one transaction per cycle; every stage holds a valid bit
// a stalled receiver freezes the whole pipeline, so in_ready follows
// out_ready while a result waits, and nothing is lost or repeated
// reset empties the pipeline and loads the default register values:
// remap off, full stretch range, gamma of one, floor of one lsb
module gamma_stretch_pixel_remap_unit
	import gsr_pkg::*;
#(
	parameter int FRACTION_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [FRACTION_BITS:0]   in_pixel,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [FRACTION_BITS:0]   out_pixel,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [2:0]               cfg_index,
	input  logic [((FRACTION_BITS+1 > 16) ? FRACTION_BITS+1 : 16)-1:0] cfg_data
);

	localparam int PW     = FRACTION_BITS + 1;
	localparam int SIDE_W = PW + 1;
	localparam logic [PW-1:0] ONE = PW'(1) << FRACTION_BITS;
	localparam int EXP_W  = 16 + NL_W - 12;
	localparam logic [QBITS+1:0] HALF = (QBITS+2)'(1) << (QBITS - FRACTION_BITS - 1);

	// square-root chain 2^-(2^-i) in q30
	function automatic logic [63:0] isqrt64(input logic [63:0] a);
		logic [63:0] rem;
		logic [63:0] res;
		logic [63:0] bitv;
		rem  = a;
		res  = '0;
		bitv = 64'd1 << 62;
		for (int n = 0; n < 32; n++) begin
			if (rem >= res + bitv) begin
				rem = rem - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic logic [QBITS-1:0] exp_factor(input int idx);
		logic [63:0] d;
		d = 64'd1 << (QBITS - 1);
		for (int n = 1; n <= idx; n++) begin
			d = isqrt64(d << QBITS);
		end
		return d[QBITS-1:0];
	endfunction

	function automatic logic [PW-1:0] clamp_out(input logic [PW-1:0] v,
			input logic [PW-1:0] mo);
		logic [PW-1:0] r;
		if (v > mo) begin
			r = (v < ONE) ? v : ONE;
		end else begin
			r = mo;
		end
		return r;
	endfunction

	// global pipeline advance
	logic adv;
	logic out_valid_q;
	logic [PW-1:0] out_pixel_q;

	assign adv       = !out_valid_q || out_ready;
	assign in_ready  = adv;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_pixel = out_pixel_q;

	// configuration registers
	logic          enable_q;
	logic [PW-1:0] smin_q;
	logic [PW-1:0] smax_q;
	logic [15:0]   gamma_q;
	logic [PW-1:0] mout_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			smin_q   <= '0;
			smax_q   <= ONE;
			gamma_q  <= 16'd4096;
			mout_q   <= PW'(1);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ENABLE:      enable_q <= cfg_data[0];
				REG_STRETCH_MIN: smin_q   <= cfg_data[PW-1:0];
				REG_STRETCH_MAX: smax_q   <= cfg_data[PW-1:0];
				REG_GAMMA:       gamma_q  <= cfg_data[15:0];
				REG_MIN_OUTPUT:  mout_q   <= cfg_data[PW-1:0];
				default: ;
			endcase
		end
	end

	// setup: special cases settle here, the rest goes to the divider
	logic          byp;
	logic [PW-1:0] bval;

	always_comb begin
		byp  = 1'b1;
		bval = '0;
		if (!enable_q) begin
			bval = in_pixel;
		end else if (in_pixel == '0) begin
			bval = '0;
		end else if (smax_q <= smin_q) begin
			bval = (in_pixel > smin_q) ? clamp_out(ONE, mout_q) : mout_q;
		end else if (in_pixel < smin_q) begin
			bval = mout_q;
		end else if (in_pixel == smin_q) begin
			bval = clamp_out((gamma_q == '0) ? ONE : '0, mout_q);
		end else if (in_pixel >= smax_q) begin
			bval = clamp_out(ONE, mout_q);
		end else begin
			byp = 1'b0;
		end
	end

	logic              v_s1;
	logic [PW-1:0]     num_s1;
	logic [PW-1:0]     den_s1;
	logic [SIDE_W-1:0] sd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s1 <= in_pixel - smin_q;
			den_s1 <= smax_q - smin_q;
			sd_s1  <= {byp, bval};
		end
	end

	// ratio in q30
	logic              div_v;
	logic [QBITS-1:0]  div_q;
	logic [SIDE_W-1:0] div_sd;

	gsr_div #(
		.PW     (PW),
		.SIDE_W (SIDE_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_v     (v_s1),
		.num      (num_s1),
		.den      (den_s1),
		.side     (sd_s1),
		.out_v    (div_v),
		.quot     (div_q),
		.side_out (div_sd)
	);

	// negated logarithm in q24
	logic              log_v;
	logic [NL_W-1:0]   log_nl;
	logic [SIDE_W-1:0] log_sd;

	gsr_log #(
		.SIDE_W (SIDE_W)
	) u_log (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_v     (div_v),
		.x30      (div_q),
		.side     (div_sd),
		.out_v    (log_v),
		.nl       (log_nl),
		.side_out (log_sd)
	);

	// scale by gamma
	logic [15+NL_W:0]  gprod;
	logic              v_s58;
	logic [EXP_W-1:0]  ex_s58;
	logic [SIDE_W-1:0] sd_s58;

	assign gprod = gamma_q * log_nl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s58 <= 1'b0;
		end else if (adv) begin
			v_s58 <= log_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ex_s58 <= gprod[15+NL_W:12];
			sd_s58 <= log_sd;
		end
	end

	// fractional power: one conditional multiply per exponent fraction bit
	logic              pv_s  [0:LOG_FRAC];
	logic [QBITS:0]    acc_s [0:LOG_FRAC];
	logic [EXP_W-1:0]  pex_s [0:LOG_FRAC];
	logic [SIDE_W-1:0] psd_s [0:LOG_FRAC];

	assign pv_s[0]  = v_s58;
	assign acc_s[0] = (QBITS+1)'(1) << QBITS;
	assign pex_s[0] = ex_s58;
	assign psd_s[0] = sd_s58;

	for (genvar i = 1; i <= LOG_FRAC; i++) begin : g_pow
		localparam logic [QBITS-1:0] FACT = exp_factor(i);
		logic [2*QBITS:0] prod;

		assign prod = acc_s[i-1] * FACT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pv_s[i] <= 1'b0;
			end else if (adv) begin
				pv_s[i] <= pv_s[i-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				acc_s[i] <= pex_s[i-1][LOG_FRAC-i] ? prod[2*QBITS:QBITS] : acc_s[i-1];
				pex_s[i] <= pex_s[i-1];
				psd_s[i] <= psd_s[i-1];
			end
		end
	end

	// integer part of the exponent as a right shift
	logic [EXP_W-LOG_FRAC-1:0] kint;
	logic              v_s83;
	logic [QBITS:0]    sh_s83;
	logic [SIDE_W-1:0] sd_s83;

	assign kint = pex_s[LOG_FRAC][EXP_W-1:LOG_FRAC];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s83 <= 1'b0;
		end else if (adv) begin
			v_s83 <= pv_s[LOG_FRAC];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sh_s83 <= (kint >= (EXP_W-LOG_FRAC)'(31)) ? '0 : (acc_s[LOG_FRAC] >> kint[4:0]);
			sd_s83 <= psd_s[LOG_FRAC];
		end
	end

	// round to pixel precision, clamp, or take the early result
	logic [QBITS+1:0] rnd;
	logic [PW-1:0]    pw_val;
	logic [PW-1:0]    res;

	always_comb begin
		rnd    = {1'b0, sh_s83} + HALF;
		pw_val = rnd[QBITS-FRACTION_BITS+PW-1:QBITS-FRACTION_BITS];
		res    = sd_s83[SIDE_W-1] ? sd_s83[PW-1:0] : clamp_out(pw_val, mout_q);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_s83;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_pixel_q <= res;
		end
	end

endmodule

/* hw/rtl/gsr_checker.sv */
// port-level checks of the gamma stretch remap unit and their binding
`include "gamma_stretch_pixel_remap_unit_macros.svh"

module gsr_checker
	import gsr_pkg::*;
#(
	parameter int FRACTION_BITS = 16
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [FRACTION_BITS:0] out_pixel,
	input logic                   cfg_ready
);

	// a waiting result stays and holds its value
	`GSR_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`GSR_ASSERT_NXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(out_pixel))

	// a stalled output freezes the pipeline, so no new transaction enters
	`GSR_ASSERT_IMP(a_stall_blocks, clk, arst_n, out_valid && !out_ready, !in_ready)

	// configuration writes are never refused
	`GSR_ASSERT_IMP(a_cfg_ready, clk, arst_n, 1'b1, cfg_ready)

endmodule

bind gamma_stretch_pixel_remap_unit gsr_checker #(
	.FRACTION_BITS (FRACTION_BITS)
) u_gsr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_pixel (out_pixel),
	.cfg_ready (cfg_ready)
);
